// ===== src/least_loaded_server_selector_macros.svh =====
// ----------------------------------------------------------------------------
// Least loaded server selector: assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef LEAST_LOADED_SERVER_SELECTOR_MACROS_SVH
`define LEAST_LOADED_SERVER_SELECTOR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define LLSS_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define LLSS_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/llss_pkg.sv =====
// ----------------------------------------------------------------------------
// Least loaded server selector: shared package
// Field widths, codes and the control bundle of the server table.
// ----------------------------------------------------------------------------
package llss_pkg;

    localparam int ID_W        = 32;
    localparam int IN_CNT_W    = 16;
    localparam int S_TDATA_W   = 64;
    localparam int S_TUSER_W   = 1;
    localparam int M_TDATA_W   = 32;
    localparam int M_TUSER_W   = 2;

    // Bit positions in m_tuser.
    localparam int M_TUSER_FOUND  = 0;
    localparam int M_TUSER_STATUS = 1;

    typedef enum logic {
        MODE_UPDATE = 1'b0,
        MODE_ALLOC  = 1'b1
    } llss_mode_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic set_valid;
    } llss_tbl_ctl_t;

endpackage

// ===== src/llss_table.sv =====
// ----------------------------------------------------------------------------
// Least loaded server selector: server table
// Key, count and limit memory with one write and one registered read port;
// valid bits live in flip-flops and are cleared by reset.
// ----------------------------------------------------------------------------
module llss_table #(
    parameter int ENTRIES = 16,
    parameter int CNT_W   = 16,
    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  llss_pkg::llss_tbl_ctl_t ctl,
    input  logic [IDX_W-1:0]      rd_addr,
    input  logic [IDX_W-1:0]      wr_addr,
    input  logic [llss_pkg::ID_W-1:0] wr_key,
    input  logic [CNT_W-1:0]      wr_count,
    input  logic [CNT_W-1:0]      wr_limit,
    output logic                  rd_valid,
    output logic [llss_pkg::ID_W-1:0] rd_key,
    output logic [CNT_W-1:0]      rd_count,
    output logic [CNT_W-1:0]      rd_limit
);
    import llss_pkg::*;

    logic [ID_W-1:0]  key_mem   [ENTRIES];
    logic [CNT_W-1:0] count_mem [ENTRIES];
    logic [CNT_W-1:0] limit_mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    logic               rd_valid_reg;
    logic [ID_W-1:0]    rd_key_reg;
    logic [CNT_W-1:0]   rd_count_reg;
    logic [CNT_W-1:0]   rd_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (ctl.wr_en && ctl.set_valid) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (ctl.rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            key_mem[wr_addr]   <= wr_key;
            count_mem[wr_addr] <= wr_count;
            limit_mem[wr_addr] <= wr_limit;
        end
        if (ctl.rd_en) begin
            rd_key_reg   <= key_mem[rd_addr];
            rd_count_reg <= count_mem[rd_addr];
            rd_limit_reg <= limit_mem[rd_addr];
        end
    end

    assign rd_valid = rd_valid_reg;
    assign rd_key   = rd_key_reg;
    assign rd_count = rd_count_reg;
    assign rd_limit = rd_limit_reg;

endmodule

// ===== src/least_loaded_server_selector.sv =====
// ----------------------------------------------------------------------------
// Least loaded server selector
// Server table with load updates and least loaded allocation by exact ratio.
// ----------------------------------------------------------------------------
//  Channel | Direction | tdata                        | tuser
//  s_      | in        | server_id, load_count, limit | mode
//  m_      | out       | chosen_id                    | found, status
//
// An item is taken only in idle; the table is then walked one entry at a
// time through its single read port. Each entry visited is read and then
// checked; in an allocate, an entry that needs the cross-multiply also goes
// through two multiply steps on the shared multiplier and a compare. The
// first entry that qualifies never needs the multiply.
// Reset empties the table at once. The result waits in the output register
// while a new item is accepted.
// ----------------------------------------------------------------------------
module least_loaded_server_selector #(
    parameter int TABLE_ENTRIES = 16,
    parameter int COUNT_BITS    = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // server_id [31:0], load_count [47:32], load_limit [63:48]
    input  logic [llss_pkg::S_TDATA_W-1:0]   s_tdata,
    // mode [0]
    input  logic [llss_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // chosen_id [31:0]
    output logic [llss_pkg::M_TDATA_W-1:0]   m_tdata,
    // found [0], status [1]
    output logic [llss_pkg::M_TUSER_W-1:0]   m_tuser
);
    import llss_pkg::*;

    `include "least_loaded_server_selector_macros.svh"

    localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int PROD_W = 2 * COUNT_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_MUL1,
        S_MUL2,
        S_CMP,
        S_DONE
    } state_t;

    state_t                 state_reg, state_next;
    llss_mode_t             mode_reg, mode_next;
    logic [ID_W-1:0]        id_reg, id_next;
    logic [COUNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [COUNT_BITS-1:0]  lim_reg, lim_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [IDX_W-1:0]       free_idx_reg, free_idx_next;
    logic                   free_hit_reg, free_hit_next;
    logic                   drop_reg, drop_next;
    logic                   have_reg, have_next;
    logic [COUNT_BITS-1:0]  best_c_reg, best_c_next;
    logic [COUNT_BITS-1:0]  best_l_reg, best_l_next;
    logic [ID_W-1:0]        best_id_reg, best_id_next;
    logic [PROD_W-1:0]      prod_reg, prod_next;
    logic [PROD_W-1:0]      lhs_reg, lhs_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic [M_TUSER_W-1:0]   m_tuser_reg, m_tuser_next;

    llss_tbl_ctl_t          tbl_ctl;
    logic [IDX_W-1:0]       wr_addr;
    logic                   rd_valid;
    logic [ID_W-1:0]        rd_key;
    logic [COUNT_BITS-1:0]  rd_count;
    logic [COUNT_BITS-1:0]  rd_limit;

    logic                   last;
    logic                   step;
    logic                   take;
    logic [COUNT_BITS-1:0]  mul_a;
    logic [COUNT_BITS-1:0]  mul_b;

    llss_table #(
        .ENTRIES (TABLE_ENTRIES),
        .CNT_W   (COUNT_BITS)
    ) u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (tbl_ctl),
        .rd_addr  (idx_reg),
        .wr_addr  (wr_addr),
        .wr_key   (id_reg),
        .wr_count (cnt_reg),
        .wr_limit (lim_reg),
        .rd_valid (rd_valid),
        .rd_key   (rd_key),
        .rd_count (rd_count),
        .rd_limit (rd_limit)
    );

    assign last = (idx_reg == IDX_W'(TABLE_ENTRIES - 1));

    // The one multiplier: count times best limit first, then best count
    // times limit.
    assign mul_a = (state_reg == S_MUL1) ? rd_count   : best_c_reg;
    assign mul_b = (state_reg == S_MUL1) ? best_l_reg : rd_limit;

    always_comb begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        id_next       = id_reg;
        cnt_next      = cnt_reg;
        lim_next      = lim_reg;
        idx_next      = idx_reg;
        free_idx_next = free_idx_reg;
        free_hit_next = free_hit_reg;
        drop_next     = drop_reg;
        have_next     = have_reg;
        best_c_next   = best_c_reg;
        best_l_next   = best_l_reg;
        best_id_next  = best_id_reg;
        prod_next     = prod_reg;
        lhs_next      = lhs_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        tbl_ctl       = '0;
        wr_addr       = idx_reg;
        step          = 1'b0;
        take          = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    mode_next     = llss_mode_t'(s_tuser[0]);
                    id_next       = s_tdata[ID_W-1:0];
                    cnt_next      = COUNT_BITS'(32'(s_tdata[ID_W +: IN_CNT_W]));
                    lim_next      = COUNT_BITS'(32'(s_tdata[ID_W + IN_CNT_W +: IN_CNT_W]));
                    idx_next      = '0;
                    free_hit_next = 1'b0;
                    drop_next     = 1'b0;
                    have_next     = 1'b0;
                    state_next    = S_READ;
                end
            end
            S_READ: begin
                tbl_ctl.rd_en = 1'b1;
                state_next    = S_CHECK;
            end
            S_CHECK: begin
                if (mode_reg == MODE_UPDATE) begin
                    if (rd_valid && rd_key == id_reg) begin
                        tbl_ctl.wr_en = 1'b1;
                        state_next    = S_DONE;
                    end else begin
                        if (!rd_valid && !free_hit_reg) begin
                            free_hit_next = 1'b1;
                            free_idx_next = idx_reg;
                        end
                        if (!last) begin
                            step = 1'b1;
                        end else begin
                            // No match anywhere: claim the first free slot seen.
                            if (free_hit_reg || !rd_valid) begin
                                tbl_ctl.wr_en     = 1'b1;
                                tbl_ctl.set_valid = 1'b1;
                                wr_addr = free_hit_reg ? free_idx_reg : idx_reg;
                            end else begin
                                drop_next = 1'b1;
                            end
                            state_next = S_DONE;
                        end
                    end
                end else begin
                    if (!rd_valid || rd_count >= rd_limit) begin
                        step = 1'b1;
                    end else if (!have_reg) begin
                        take = 1'b1;
                        step = 1'b1;
                    end else begin
                        state_next = S_MUL1;
                    end
                end
            end
            S_MUL1: begin
                prod_next  = PROD_W'(mul_a) * PROD_W'(mul_b);
                state_next = S_MUL2;
            end
            S_MUL2: begin
                lhs_next   = prod_reg;
                prod_next  = PROD_W'(mul_a) * PROD_W'(mul_b);
                state_next = S_CMP;
            end
            S_CMP: begin
                if (lhs_reg < prod_reg || (lhs_reg == prod_reg && rd_key < best_id_reg)) begin
                    take = 1'b1;
                end
                step = 1'b1;
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = (mode_reg == MODE_ALLOC && have_reg) ? best_id_reg : '0;
                    m_tuser_next  = '0;
                    m_tuser_next[M_TUSER_FOUND]  = (mode_reg == MODE_ALLOC) && have_reg;
                    m_tuser_next[M_TUSER_STATUS] = (mode_reg == MODE_UPDATE) && drop_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (take) begin
            have_next    = 1'b1;
            best_c_next  = rd_count;
            best_l_next  = rd_limit;
            best_id_next = rd_key;
        end
        if (step) begin
            if (last) begin
                state_next = S_DONE;
            end else begin
                idx_next   = IDX_W'(idx_reg + 1'b1);
                state_next = S_READ;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg     <= mode_next;
        id_reg       <= id_next;
        cnt_reg      <= cnt_next;
        lim_reg      <= lim_next;
        idx_reg      <= idx_next;
        free_idx_reg <= free_idx_next;
        free_hit_reg <= free_hit_next;
        drop_reg     <= drop_next;
        have_reg     <= have_next;
        best_c_reg   <= best_c_next;
        best_l_reg   <= best_l_next;
        best_id_reg  <= best_id_next;
        prod_reg     <= prod_next;
        lhs_reg      <= lhs_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `LLSS_ASSERT_IMP(a_no_pick_zero_id, m_tvalid && !m_tuser[M_TUSER_FOUND], m_tdata == '0, "id set without a pick")
    `LLSS_ASSERT_IMP(a_flags_exclusive, m_tvalid, !(&m_tuser), "found and dropped together")
    `LLSS_ASSERT_NXT(a_accept_goes_busy, s_tvalid && s_tready, !s_tready, "ready right after an accepted item")
    `LLSS_ASSERT_IMP(a_result_from_done, $rose(m_tvalid_reg), $past(state_reg == S_DONE), "result loaded outside the done step")

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// Least loaded server selector: self-checking testbench
// A directed table of updates and allocations fills the server table, then
// random load updates and allocations run against an in-bench model of the
// table. Results are checked field by field, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;

    import llss_pkg::*;

    localparam int NUM_SERVERS = 16;
    localparam int LOAD_BITS   = 16;
    localparam int RANDOM_ITEMS = 800;
    localparam int QUIET_TAIL   = 80;

    typedef struct packed {
        logic [ID_W-1:0] chosen_id;
        logic            found;
        logic            status;
    } server_result_t;

    typedef struct {
        llss_mode_t           mode;
        logic [ID_W-1:0]      id;
        logic [LOAD_BITS-1:0] count;
        logic [LOAD_BITS-1:0] limit;
        bit                   has_fixed;
        server_result_t       fixed;
    } stim_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    // Model of the server table.
    logic                 srv_valid [NUM_SERVERS];
    logic [ID_W-1:0]      srv_id    [NUM_SERVERS];
    logic [LOAD_BITS-1:0] srv_count [NUM_SERVERS];
    logic [LOAD_BITS-1:0] srv_limit [NUM_SERVERS];

    server_result_t pending_results[$];
    stim_row_t      directed_rows[$];

    bit idle_on = 1'b1;
    int error_count = 0;
    int n_updates = 0;
    int n_allocs = 0;
    int n_found = 0;
    int n_dropped = 0;

    always #1 aclk = ~aclk;

    least_loaded_server_selector #(
        .TABLE_ENTRIES (NUM_SERVERS),
        .COUNT_BITS    (LOAD_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Applies one item to the table model and returns the result it causes.
    function automatic server_result_t predict_server_result(
        llss_mode_t mode, logic [ID_W-1:0] id,
        logic [LOAD_BITS-1:0] count, logic [LOAD_BITS-1:0] limit);
        server_result_t res;
        int             free_slot;
        bit             matched;
        logic [31:0]    c, l, best_c, best_l, lhs, rhs;
        logic [ID_W-1:0] best_id;
        res = '0;
        free_slot = -1;
        matched = 1'b0;
        if (mode == MODE_UPDATE) begin
            for (int i = 0; i < NUM_SERVERS; i++) begin
                if (!matched && srv_valid[i] && srv_id[i] == id) begin
                    srv_count[i] = count;
                    srv_limit[i] = limit;
                    matched = 1'b1;
                end
                if (!srv_valid[i] && free_slot < 0)
                    free_slot = i;
            end
            if (!matched) begin
                if (free_slot < 0) begin
                    res.status = 1'b1;
                end else begin
                    srv_valid[free_slot] = 1'b1;
                    srv_id[free_slot] = id;
                    srv_count[free_slot] = count;
                    srv_limit[free_slot] = limit;
                end
            end
        end else begin
            best_c = 0;
            best_l = 1;
            best_id = '0;
            for (int i = 0; i < NUM_SERVERS; i++) begin
                c = 32'(srv_count[i]);
                l = 32'(srv_limit[i]);
                if (srv_valid[i] && c < l) begin
                    // Ratios are compared exactly: c/l < bc/bl iff c*bl < bc*l.
                    lhs = c * best_l;
                    rhs = best_c * l;
                    if (!res.found || lhs < rhs || (lhs == rhs && srv_id[i] < best_id)) begin
                        best_c = c;
                        best_l = l;
                        best_id = srv_id[i];
                    end
                    res.found = 1'b1;
                end
            end
            res.chosen_id = res.found ? best_id : '0;
        end
        return res;
    endfunction

    task automatic add_row(llss_mode_t mode, logic [ID_W-1:0] id,
                           logic [LOAD_BITS-1:0] count, logic [LOAD_BITS-1:0] limit,
                           bit has_fixed, logic [ID_W-1:0] fixed_id,
                           logic fixed_found, logic fixed_status);
        stim_row_t row;
        row.mode = mode;
        row.id = id;
        row.count = count;
        row.limit = limit;
        row.has_fixed = has_fixed;
        row.fixed = '{chosen_id: fixed_id, found: fixed_found, status: fixed_status};
        directed_rows.push_back(row);
    endtask

    // Offers one item, waits for it to be taken and records what it should return.
    task automatic send_item(llss_mode_t mode, logic [ID_W-1:0] id,
                             logic [LOAD_BITS-1:0] count, logic [LOAD_BITS-1:0] limit,
                             bit has_fixed, server_result_t fixed);
        server_result_t predicted;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {limit, count, id};
        s_tuser <= mode;
        do @(posedge aclk); while (!s_tready);
        predicted = predict_server_result(mode, id, count, limit);
        pending_results.push_back(has_fixed ? fixed : predicted);
        if (mode == MODE_UPDATE) begin
            n_updates++;
            if (predicted.status)
                n_dropped++;
        end else begin
            n_allocs++;
            if (predicted.found)
                n_found++;
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    // Receiver: ready drops for short random bursts while idling is enabled.
    initial begin : result_sink
        @(posedge aclk);
        forever begin
            if (idle_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with no item pending: chosen_id %h tuser %b",
                         $time, m_tdata, m_tuser);
                error_count++;
            end else begin
                server_result_t want;
                want = pending_results.pop_front();
                if (m_tdata[ID_W-1:0] !== want.chosen_id) begin
                    $display("%0t: chosen_id expected %h actual %h",
                             $time, want.chosen_id, m_tdata[ID_W-1:0]);
                    error_count++;
                end
                if (m_tuser[M_TUSER_FOUND] !== want.found) begin
                    $display("%0t: found expected %b actual %b",
                             $time, want.found, m_tuser[M_TUSER_FOUND]);
                    error_count++;
                end
                if (m_tuser[M_TUSER_STATUS] !== want.status) begin
                    $display("%0t: status expected %b actual %b",
                             $time, want.status, m_tuser[M_TUSER_STATUS]);
                    error_count++;
                end
            end
        end
    end

    initial begin : stimulus
        llss_mode_t           mode;
        logic [ID_W-1:0]      id;
        logic [LOAD_BITS-1:0] count, limit;
        int                   c0, l0, k;
        for (int i = 0; i < NUM_SERVERS; i++) begin
            srv_valid[i] = 1'b0;
            srv_id[i] = '0;
            srv_count[i] = '0;
            srv_limit[i] = '0;
        end

        // Empty table, zero limit, server id zero, overwrite of a known id.
        add_row(MODE_ALLOC,  32'h0000_0000, 16'h0000, 16'h0000, 1, 32'h0, 1'b0, 1'b0);
        add_row(MODE_UPDATE, 32'h0000_0000, 16'h0000, 16'h0000, 1, 32'h0, 1'b0, 1'b0);
        add_row(MODE_ALLOC,  32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1, 32'h0, 1'b0, 1'b0);
        add_row(MODE_UPDATE, 32'h0000_0000, 16'h0000, 16'h0001, 1, 32'h0, 1'b0, 1'b0);
        add_row(MODE_ALLOC,  32'h0000_0000, 16'h0000, 16'h0000, 1, 32'h0, 1'b1, 1'b0);
        add_row(MODE_UPDATE, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1, 32'h0, 1'b0, 1'b0);
        // Equal ratios on ids 3 and 5; the lower id must win.
        add_row(MODE_UPDATE, 32'h0000_0005, 16'h0001, 16'h0002, 0, 32'h0, 1'b0, 1'b0);
        add_row(MODE_UPDATE, 32'h0000_0003, 16'h0002, 16'h0004, 0, 32'h0, 1'b0, 1'b0);
        add_row(MODE_UPDATE, 32'h0000_0000, 16'h0001, 16'h0001, 0, 32'h0, 1'b0, 1'b0);
        add_row(MODE_ALLOC,  32'h0000_0000, 16'h0000, 16'h0000, 0, 32'h0, 1'b0, 1'b0);
        add_row(MODE_UPDATE, 32'h0000_0007, 16'hFFFE, 16'hFFFF, 0, 32'h0, 1'b0, 1'b0);
        add_row(MODE_UPDATE, 32'h0000_0009, 16'h0000, 16'hFFFF, 0, 32'h0, 1'b0, 1'b0);
        add_row(MODE_ALLOC,  32'h0000_0000, 16'h0000, 16'h0000, 0, 32'h0, 1'b0, 1'b0);
        // Fill the remaining slots.
        add_row(MODE_UPDATE, 32'h0000_0001, 16'h0001, 16'h0003, 0, 32'h0, 1'b0, 1'b0);
        add_row(MODE_UPDATE, 32'h8000_0000, 16'h0000, 16'h0005, 0, 32'h0, 1'b0, 1'b0);
        add_row(MODE_UPDATE, 32'hAAAA_AAAA, 16'h0003, 16'h0009, 0, 32'h0, 1'b0, 1'b0);
        add_row(MODE_UPDATE, 32'h5555_5555, 16'h0001, 16'h0003, 0, 32'h0, 1'b0, 1'b0);
        add_row(MODE_UPDATE, 32'h0000_0002, 16'h0004, 16'h0004, 0, 32'h0, 1'b0, 1'b0);
        add_row(MODE_UPDATE, 32'h1234_5678, 16'h000A, 16'h0064, 0, 32'h0, 1'b0, 1'b0);
        add_row(MODE_UPDATE, 32'hFFFF_FFFE, 16'h0000, 16'h0000, 0, 32'h0, 1'b0, 1'b0);
        add_row(MODE_UPDATE, 32'h0F0F_0F0F, 16'h0002, 16'h0006, 0, 32'h0, 1'b0, 1'b0);
        add_row(MODE_UPDATE, 32'h7FFF_FFFF, 16'hFFFE, 16'hFFFF, 0, 32'h0, 1'b0, 1'b0);
        add_row(MODE_UPDATE, 32'h0000_0100, 16'h0008, 16'h0010, 0, 32'h0, 1'b0, 1'b0);
        // The table is full now, so a new id is dropped.
        add_row(MODE_UPDATE, 32'hDEAD_BEEF, 16'h0001, 16'h0002, 1, 32'h0, 1'b0, 1'b1);
        add_row(MODE_ALLOC,  32'h0000_0000, 16'h0000, 16'h0000, 0, 32'h0, 1'b0, 1'b0);
        add_row(MODE_UPDATE, 32'h0000_0009, 16'h0001, 16'h0001, 0, 32'h0, 1'b0, 1'b0);
        add_row(MODE_ALLOC,  32'h0000_0000, 16'h0000, 16'h0000, 0, 32'h0, 1'b0, 1'b0);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[r])
            send_item(directed_rows[r].mode, directed_rows[r].id, directed_rows[r].count,
                      directed_rows[r].limit, directed_rows[r].has_fixed,
                      directed_rows[r].fixed);
        drain_results();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2)
                drain_results();
            if (n == RANDOM_ITEMS - QUIET_TAIL)
                idle_on = 1'b0;
            mode = ($urandom_range(0, 9) < 3) ? MODE_ALLOC : MODE_UPDATE;
            // Most updates hit a known server; a few use a fresh id and get dropped.
            if (mode == MODE_UPDATE && $urandom_range(0, 6) != 0)
                id = srv_id[$urandom_range(0, NUM_SERVERS - 1)];
            else
                id = $urandom;
            case ($urandom_range(0, 4))
                0: begin
                    count = LOAD_BITS'($urandom);
                    limit = LOAD_BITS'($urandom);
                end
                1: begin
                    count = LOAD_BITS'($urandom_range(0, 7));
                    limit = LOAD_BITS'($urandom_range(0, 7));
                end
                2: begin
                    limit = LOAD_BITS'($urandom);
                    count = LOAD_BITS'($urandom_range(32'(limit), 32'hFFFF));
                end
                3: begin
                    // Scaled copies of small ratios give exact ties.
                    c0 = $urandom_range(0, 3);
                    l0 = $urandom_range(1, 4);
                    k = $urandom_range(1, 16383);
                    count = LOAD_BITS'(c0 * k);
                    limit = LOAD_BITS'(l0 * k);
                end
                default: begin
                    limit = LOAD_BITS'($urandom_range(1, 32'hFFFF));
                    count = LOAD_BITS'($urandom_range(0, 32'(limit) - 1));
                end
            endcase
            send_item(mode, id, count, limit, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (100) @(posedge aclk);

        $display("Ran %0d updates (%0d dropped on a full table) and %0d allocations",
                 n_updates, n_dropped, n_allocs);
        $display("(%0d found a server), with random stalls on both channels.", n_found);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin : watchdog
        #1000000;
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/llss_pkg.sv
src/llss_table.sv
src/least_loaded_server_selector.sv
test/tb_top.sv
